// File: design/protobuf_field_skipper_top_assert.svh
// assertion macros for the protobuf field skipper
// expects clk_i and rst_ni in the scope of every use
`ifndef PROTOBUF_FIELD_SKIPPER_TOP_ASSERT_SVH
`define PROTOBUF_FIELD_SKIPPER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// check that holds while out of reset
`define PFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check that holds at every edge, reset included
`define PFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PFS_ASSERT(label, prop, msg)
`define PFS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: design/pfs_pkg.sv
// shared types and constants of the protobuf field skipper
// used by pfs_core and protobuf_field_skipper_top, no dependencies
package pfs_pkg;

  localparam int unsigned MAX_GROUP_DEPTH = 16;
  localparam int unsigned OFFSET_BITS     = 32;
  localparam int unsigned GD_W            = $clog2(MAX_GROUP_DEPTH + 1);

  // index of the last byte a varint may have
  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
  // highest varint byte index that still lands bits in a 32-bit length
  localparam logic [3:0] LEN_LAST_IDX    = 4'd4;

  // wire types
  localparam logic [2:0] WT_VARINT    = 3'd0;
  localparam logic [2:0] WT_FIXED64   = 3'd1;
  localparam logic [2:0] WT_LEN       = 3'd2;
  localparam logic [2:0] WT_GRP_START = 3'd3;
  localparam logic [2:0] WT_GRP_END   = 3'd4;
  localparam logic [2:0] WT_FIXED32   = 3'd5;
  localparam logic [2:0] WT_BAD6      = 3'd6;
  localparam logic [2:0] WT_BAD7      = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_VARINT,
    PH_LEN,
    PH_SKIP
  } pfs_phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_VARINT_LONG,
    ST_UNEXP_END,
    ST_ILLEGAL_TYPE,
    ST_NEG_LEN,
    ST_TOO_DEEP
  } pfs_status_e;

  // one result from the parser
  typedef struct packed {
    logic        valid;
    logic [31:0] end_offset;
    pfs_status_e status;
  } pfs_res_t;

endpackage

// File: design/pfs_core.sv
// byte-wise wire-format parser: tag, varint, length and skip phases
// depends on pfs_pkg and the assertion header
`include "protobuf_field_skipper_top_assert.svh"

module pfs_core import pfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] start_offset_i,
  output pfs_res_t    res_o
);

  pfs_phase_e             phase_q, phase_d;
  logic [3:0]             shift_q, shift_d;
  logic [31:0]            acc_q, acc_d;
  logic [31:0]            skip_q, skip_d;
  logic [GD_W-1:0]        gd_q, gd_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;

  pfs_phase_e             ph;
  logic [3:0]             sh;
  logic [31:0]            acc, acc_n, sk, sk_n;
  logic [GD_W-1:0]        gd;
  logic [OFFSET_BITS-1:0] off1, fin_ofs;
  logic                   active, more, fin_v;
  logic [2:0]             wt;
  pfs_status_e            fin_st;

  // next state for one accepted word
  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    acc_d   = acc_q;
    skip_d  = skip_q;
    gd_d    = gd_q;
    off_d   = off_q;
    fin_v   = 1'b0;
    fin_st  = ST_OK;
    fin_ofs = '0;
    active  = step_i && (first_byte_i || (phase_q != PH_IDLE));
    more    = data_byte_i[7];
    // a first byte restarts the request from its own offset
    ph   = first_byte_i ? PH_TAG : phase_q;
    sh   = first_byte_i ? 4'd0 : shift_q;
    acc  = first_byte_i ? 32'd0 : acc_q;
    sk   = first_byte_i ? 32'd0 : skip_q;
    gd   = first_byte_i ? '0 : gd_q;
    off1 = (first_byte_i ? OFFSET_BITS'(start_offset_i) : off_q) + OFFSET_BITS'(1);
    wt    = sk[2:0];
    acc_n = acc;
    sk_n  = sk;

    if (active) begin
      phase_d = ph;
      shift_d = sh;
      acc_d   = acc;
      skip_d  = sk;
      gd_d    = gd;
      off_d   = off1;

      unique case (ph)
        PH_TAG: begin
          if (sh == 4'd0) begin
            sk_n   = 32'(data_byte_i[2:0]);
            skip_d = sk_n;
          end
          wt = sk_n[2:0];
          if (more) begin
            if (sh >= VARINT_LAST_IDX) begin
              fin_v  = 1'b1;
              fin_st = ST_VARINT_LONG;
            end else begin
              shift_d = sh + 4'd1;
            end
          end else begin
            unique case (wt) inside
              WT_VARINT: begin
                phase_d = PH_VARINT;
                shift_d = 4'd0;
                acc_d   = 32'd0;
              end
              WT_LEN: begin
                phase_d = PH_LEN;
                shift_d = 4'd0;
                acc_d   = 32'd0;
              end
              WT_BAD6, WT_BAD7: begin
                fin_v  = 1'b1;
                fin_st = ST_ILLEGAL_TYPE;
              end
              WT_GRP_START: begin
                if (gd >= GD_W'(MAX_GROUP_DEPTH)) begin
                  fin_v  = 1'b1;
                  fin_st = ST_TOO_DEEP;
                end else begin
                  gd_d    = gd + GD_W'(1);
                  phase_d = PH_TAG;
                  shift_d = 4'd0;
                  acc_d   = 32'd0;
                end
              end
              WT_GRP_END: begin
                if (gd <= GD_W'(1)) begin
                  gd_d    = '0;
                  fin_v   = 1'b1;
                  fin_ofs = off1;
                end else begin
                  gd_d    = gd - GD_W'(1);
                  phase_d = PH_TAG;
                  shift_d = 4'd0;
                  acc_d   = 32'd0;
                end
              end
              WT_FIXED64, WT_FIXED32: begin
                // fixed widths: 8 or 4 bytes
                if (gd == '0) begin
                  fin_v   = 1'b1;
                  fin_ofs = off1 + ((wt == WT_FIXED64) ? OFFSET_BITS'(8) : OFFSET_BITS'(4));
                end else begin
                  phase_d = PH_SKIP;
                  skip_d  = (wt == WT_FIXED64) ? 32'd8 : 32'd4;
                end
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
        PH_VARINT: begin
          if (more) begin
            if (sh >= VARINT_LAST_IDX) begin
              fin_v  = 1'b1;
              fin_st = ST_VARINT_LONG;
            end else begin
              shift_d = sh + 4'd1;
            end
          end else if (gd == '0) begin
            fin_v   = 1'b1;
            fin_ofs = off1;
          end else begin
            phase_d = PH_TAG;
            shift_d = 4'd0;
            acc_d   = 32'd0;
          end
        end
        PH_LEN: begin
          // 7 bits per byte, bits past 32 dropped
          case (sh)
            4'd0:    acc_n = acc | 32'(data_byte_i[6:0]);
            4'd1:    acc_n = acc | (32'(data_byte_i[6:0]) << 7);
            4'd2:    acc_n = acc | (32'(data_byte_i[6:0]) << 14);
            4'd3:    acc_n = acc | (32'(data_byte_i[6:0]) << 21);
            LEN_LAST_IDX: acc_n = acc | {data_byte_i[3:0], 28'd0};
            default: acc_n = acc;
          endcase
          acc_d = acc_n;
          if (more) begin
            if (sh >= VARINT_LAST_IDX) begin
              fin_v  = 1'b1;
              fin_st = ST_VARINT_LONG;
            end else begin
              shift_d = sh + 4'd1;
            end
          end else if (acc_n[31]) begin
            fin_v  = 1'b1;
            fin_st = ST_NEG_LEN;
          end else if (gd == '0) begin
            fin_v   = 1'b1;
            fin_ofs = off1 + OFFSET_BITS'(acc_n);
          end else if (acc_n == 32'd0) begin
            phase_d = PH_TAG;
            shift_d = 4'd0;
            acc_d   = 32'd0;
          end else begin
            phase_d = PH_SKIP;
            skip_d  = acc_n;
          end
        end
        PH_SKIP: begin
          sk_n   = (sk != 32'd0) ? (sk - 32'd1) : sk;
          skip_d = sk_n;
          if (sk_n == 32'd0) begin
            phase_d = PH_TAG;
            shift_d = 4'd0;
            acc_d   = 32'd0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      // buffer ran out with the field still open
      if (!fin_v && (phase_d != PH_IDLE) && last_byte_i) begin
        fin_v  = 1'b1;
        fin_st = ST_UNEXP_END;
      end
      if (fin_v) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // result word
  always_comb begin
    res_o.valid      = fin_v;
    res_o.status     = fin_st;
    res_o.end_offset = (fin_st == ST_OK) ? 32'(fin_ofs) : 32'd0;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= 4'd0;
      acc_q   <= 32'd0;
      skip_q  <= 32'd0;
      gd_q    <= '0;
      off_q   <= '0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      acc_q   <= acc_d;
      skip_q  <= skip_d;
      gd_q    <= gd_d;
      off_q   <= off_d;
    end
  end

  `PFS_ASSERT(a_depth_bound, gd_q <= GD_W'(MAX_GROUP_DEPTH), "group depth past limit")
  `PFS_ASSERT(a_shift_bound, shift_q <= VARINT_LAST_IDX, "varint byte count past limit")
  `PFS_ASSERT(a_idle_ignore,
    step_i && !first_byte_i && (phase_q == PH_IDLE) |=> $stable(off_q) && (phase_q == PH_IDLE),
    "idle word changed parser state")

endmodule

// File: design/protobuf_field_skipper_top.sv
// top level of the protobuf field skipper: stream ports and result register
// depends on pfs_pkg, pfs_core and the assertion header
//
//  channel  dir  word                        accepted when
//  s_axis   in   one buffer byte + offset    s_axis_tvalid && s_axis_tready
//  m_axis   out  end offset and status       m_axis_tvalid && m_axis_tready
//
// one byte per cycle while no untaken result stalls the input; the parse step for a byte
// is combinational from the parser state registers into the result register
// a result appears in the cycle after the byte that ends the field or the error
// rst_ni clears the parser to idle and empties the result register
// s_axis_tready drops only while an untaken result sits in the register
`include "protobuf_field_skipper_top_assert.svh"

module protobuf_field_skipper_top import pfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_byte[7:0], start_offset[39:8]
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // end_offset[31:0], status[34:32], zero[39:35]
);

  pfs_res_t    res;
  logic        step;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_end_q, out_end_d;
  pfs_status_e out_st_q, out_st_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  pfs_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (s_axis_tdata[7:0]),
    .first_byte_i   (s_axis_tuser),
    .last_byte_i    (s_axis_tlast),
    .start_offset_i (s_axis_tdata[39:8]),
    .res_o          (res)
  );

  // result register load and drain
  always_comb begin
    out_valid_d = out_valid_q;
    out_end_d   = out_end_q;
    out_st_d    = out_st_q;
    if (step && res.valid) begin
      out_valid_d = 1'b1;
      out_end_d   = res.end_offset;
      out_st_d    = res.status;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    out_end_q <= out_end_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_st_q, out_end_q};

  `PFS_ASSERT_ALWAYS(a_ready_full, !s_axis_tready |-> out_valid_q, "input stalled with empty result register")
  `PFS_ASSERT(a_err_zero, out_valid_q && (out_st_q != ST_OK) |-> (out_end_q == 32'd0), "error result carries an offset")
  `PFS_ASSERT(a_load, step && res.valid |=> out_valid_q && (out_st_q == $past(res.status)), "result not captured")

endmodule
